// ===== design/iea_pkg.sv =====
// shared widths, register indexes and saturation helpers for the energy accumulator
package iea_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 16;
  localparam int StateW  = 32;
  localparam int SumW    = 31;
  localparam int CfgIdxW = 3;
  localparam int DigitsN = 8;   // radix-4 digits in a 16-bit coefficient
  localparam int AccW    = 36;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic signed [StateW-1:0] state_t;
  typedef logic [SumW-1:0] sum_t;

  localparam cfg_idx_t REG_A1      = 3'd0;
  localparam cfg_idx_t REG_A2      = 3'd1;
  localparam cfg_idx_t REG_BX      = 3'd2;
  localparam cfg_idx_t REG_BU_PREV = 3'd3;
  localparam cfg_idx_t REG_BU_CUR  = 3'd4;

  localparam state_t POS_MAX    = 32'sh7FFF_FFFF;
  localparam state_t NEG_MIN    = 32'sh8000_0000;
  localparam sum_t   SQ_POS_SAT = 31'h7FFF_FFFE;
  localparam sum_t   SQ_NEG_SAT = 31'h7FFF_FFFF;
  localparam sum_t   SUM_MAX    = 31'h7FFF_FFFF;

  // clamp a 33-bit signed value into 32 bits
  function automatic state_t sat32(input logic signed [StateW:0] v);
    state_t r;
    if (v[StateW] != v[StateW-1]) begin
      r = v[StateW] ? NEG_MIN : POS_MAX;
    end else begin
      r = v[StateW-1:0];
    end
    return r;
  endfunction

  // square of sat(w * 2^16) in q31, given 2*w*w from the multiplier for the in-range case
  function automatic sum_t sq_of(input state_t w, input sum_t prod2);
    sum_t r;
    if (w > 32'sd32767) begin
      r = SQ_POS_SAT;
    end else if (w < -32'sd32767) begin
      r = SQ_NEG_SAT;
    end else begin
      r = prod2;
    end
    return r;
  endfunction

  // saturating add of two non-negative 31-bit values
  function automatic sum_t add_sat(input sum_t a, input sum_t b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? SUM_MAX : s[SumW-1:0];
  endfunction

endpackage

// ===== design/iir_energy_accumulator_top.sv =====
// top level: second-order recursion with energy sums on a shared radix-4 serial multiplier
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+-------------------
//   input   | in_sample, in_frame_end                      | in_valid / in_ready
//   result  | out_voltage_energy, out_displacement_energy  | out_valid / out_ready
//   config  | cfg_idx, cfg_wdata                           | cfg_we, no wait
//
// each item runs seven 16x32 products through one multiplier that retires two coefficient
// bits a cycle, with a load and a post step per product, plus a step for the recursion
// output, one for the result hand-off and the accept step in idle.
// rst_n is synchronous, active low, and clears coefficients, state and sums.
// a result waits in the output register while the next item is taken; only if a new
// frame end finishes while the old result is still held does the block stall.
module iir_energy_accumulator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [iea_pkg::SampleW-1:0]  in_sample,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [iea_pkg::SumW-1:0]            out_voltage_energy,
  output logic [iea_pkg::SumW-1:0]            out_displacement_energy,
  input  logic                                cfg_we,
  input  logic [iea_pkg::CfgIdxW-1:0]         cfg_idx,
  input  logic [iea_pkg::CoefW-1:0]           cfg_wdata
);
  import iea_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_POST, ST_YCALC, ST_EMIT
  } fsm_t;

  typedef enum logic [2:0] {
    OP_A1, OP_A2, OP_BU_CUR, OP_BU_PREV, OP_BX, OP_SQ_U, OP_SQ_V
  } op_t;

  fsm_t   state_r;
  op_t    op_r;
  logic [2:0] digit_r;

  logic signed [CoefW-1:0] coef_a1_r, coef_a2_r, coef_bx_r, coef_bu_prev_r, coef_bu_cur_r;

  state_t p_r, q_r, y_r, t_r, w_r, v_r;
  logic signed [SampleW-1:0] x_r;
  logic   fe_r;
  sum_t   sum_v_r, sum_d_r;
  sum_t   out_v_r, out_d_r;
  logic   out_valid_r;

  // serial multiplier registers
  state_t                  mcand_r;
  logic [CoefW-1:0]        mplr_r;
  logic signed [AccW-1:0]  acc_r;
  logic [CoefW-1:0]        low_r;
  logic                    spec_r;

  // operand selection for the next product
  state_t                  ld_mcand;
  logic signed [CoefW-1:0] ld_mplr;

  always_comb begin
    case (op_r)
      OP_A1:      begin ld_mcand = p_r; ld_mplr = coef_a1_r;      end
      OP_A2:      begin ld_mcand = q_r; ld_mplr = coef_a2_r;      end
      OP_BU_CUR:  begin ld_mcand = y_r; ld_mplr = coef_bu_cur_r;  end
      OP_BU_PREV: begin ld_mcand = p_r; ld_mplr = coef_bu_prev_r; end
      OP_BX:      begin ld_mcand = y_r; ld_mplr = coef_bx_r;      end
      OP_SQ_U: begin
        ld_mcand = StateW'($signed(w_r[CoefW-1:0]));
        ld_mplr  = w_r[CoefW-1:0];
      end
      OP_SQ_V: begin
        ld_mcand = StateW'($signed(v_r[CoefW-1:0]));
        ld_mplr  = v_r[CoefW-1:0];
      end
      default: begin ld_mcand = p_r; ld_mplr = coef_a1_r; end
    endcase
  end

  // one radix-4 digit: top digit carries the coefficient sign
  logic                    last_digit;
  logic signed [AccW-1:0]  mc_ext, part0, part1, step_sum;

  assign last_digit = (digit_r == 3'(DigitsN - 1));
  assign mc_ext     = AccW'(mcand_r);
  assign part0      = mplr_r[0] ? mc_ext : '0;
  assign part1      = mplr_r[1] ? (last_digit ? -(mc_ext <<< 1) : (mc_ext <<< 1)) : '0;
  assign step_sum   = acc_r + part0 + part1;

  // product views: q15 scaling for coefficients, doubled low half for squares
  state_t mq_val;
  sum_t   sq_prod2;
  sum_t   sq_val;

  assign mq_val   = spec_r ? POS_MAX : {acc_r[StateW-2:0], low_r[CoefW-1]};
  assign sq_prod2 = {acc_r[13:0], low_r, 1'b0};
  assign sq_val   = sq_of((op_r == OP_SQ_U) ? w_r : v_r, sq_prod2);

  assign in_ready                = (state_r == ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_voltage_energy      = out_v_r;
  assign out_displacement_energy = out_d_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a1_r      <= '0;
      coef_a2_r      <= '0;
      coef_bx_r      <= '0;
      coef_bu_prev_r <= '0;
      coef_bu_cur_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_A1:      coef_a1_r      <= cfg_wdata;
        REG_A2:      coef_a2_r      <= cfg_wdata;
        REG_BX:      coef_bx_r      <= cfg_wdata;
        REG_BU_PREV: coef_bu_prev_r <= cfg_wdata;
        REG_BU_CUR:  coef_bu_cur_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_A1;
      digit_r     <= '0;
      p_r         <= '0;
      q_r         <= '0;
      sum_v_r     <= '0;
      sum_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !(state_r == ST_EMIT && fe_r)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample;
            fe_r    <= in_frame_end;
            op_r    <= OP_A1;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mcand_r <= ld_mcand;
          mplr_r  <= ld_mplr;
          spec_r  <= (ld_mcand == NEG_MIN) && (ld_mplr == -16'sd32768);
          acc_r   <= '0;
          digit_r <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          acc_r   <= step_sum >>> 2;
          low_r   <= {step_sum[1:0], low_r[CoefW-1:2]};
          mplr_r  <= mplr_r >> 2;
          digit_r <= digit_r + 3'd1;
          if (last_digit) begin
            state_r <= ST_POST;
          end
        end
        ST_POST: begin
          case (op_r)
            OP_A1: begin
              t_r     <= sat32({mq_val, 1'b0});
              op_r    <= OP_A2;
              state_r <= ST_LOAD;
            end
            OP_A2: begin
              t_r     <= sat32(33'(t_r) + 33'(mq_val));
              op_r    <= OP_BU_CUR;
              state_r <= ST_YCALC;
            end
            OP_BU_CUR: begin
              t_r     <= mq_val;
              op_r    <= OP_BU_PREV;
              state_r <= ST_LOAD;
            end
            OP_BU_PREV: begin
              w_r     <= sat32(33'(t_r) + 33'(mq_val));
              op_r    <= OP_BX;
              state_r <= ST_LOAD;
            end
            OP_BX: begin
              v_r     <= mq_val;
              op_r    <= OP_SQ_U;
              state_r <= ST_LOAD;
            end
            OP_SQ_U: begin
              sum_v_r <= add_sat(sum_v_r, sq_val);
              op_r    <= OP_SQ_V;
              state_r <= ST_LOAD;
            end
            default: begin
              sum_d_r <= add_sat(sum_d_r, sq_val);
              q_r     <= p_r;
              p_r     <= y_r;
              state_r <= ST_EMIT;
            end
          endcase
        end
        ST_YCALC: begin
          // recursion output from input and feedback
          y_r     <= sat32(33'(x_r) - 33'(t_r));
          state_r <= ST_LOAD;
        end
        ST_EMIT: begin
          if (!fe_r) begin
            state_r <= ST_IDLE;
          end else if (!out_valid_r || out_ready) begin
            out_v_r     <= sum_v_r;
            out_d_r     <= sum_d_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
